[design/dmpt_pkg.sv]
`default_nettype none

package dmpt_pkg;

    // operation codes
    localparam logic [1:0] OP_TRACK_MUON = 2'd0;
    localparam logic [1:0] OP_MUON       = 2'd1;
    localparam logic [1:0] OP_DECIDE     = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_TRACK_MUON_PT_THR = 2'd0;
    localparam logic [1:0] REG_MUON_PT_THR       = 2'd1;
    localparam logic [1:0] REG_QUALITY_THR       = 2'd2;

    // configuration reset values
    localparam logic [8:0] TRACK_MUON_PT_THR_RST = 9'd40;
    localparam logic [8:0] MUON_PT_THR_RST       = 9'd40;
    localparam logic [3:0] QUALITY_THR_RST       = 4'd4;

    // fixed point angles, 1/1024 units
    localparam logic [12:0]        PI_FX     = 13'd3217;
    localparam logic signed [13:0] TWO_PI_FX = 14'sd6434;
    // squared delta-R cut, 0.25 * 1024^2
    localparam logic [26:0]        DR2_LIMIT = 27'd262144;

    // one stored candidate
    typedef struct packed {
        logic signed [12:0] eta;
        logic signed [12:0] phi;
    } dmpt_cand_t;

    // controller to datapath
    typedef struct packed {
        logic load_track;
        logic load_muon;
        logic scan_start;
        logic scan_issue;
        logic clear_counts;
    } dmpt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic any_empty;
        logic pair_last;
        logic pipe_busy;
    } dmpt_status_t;

endpackage

`default_nettype wire

[design/dmpt_ctrl.sv]
`default_nettype none

module dmpt_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         operation,
    input  wire logic               zero_bias,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output dmpt_pkg::dmpt_cmd_t     cmd,
    input  wire dmpt_pkg::dmpt_status_t status
);
    import dmpt_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       in_take;

    // a decide request waits until the previous answer is taken
    always_comb
    begin
        in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || (operation != OP_DECIDE));
    end

    assign in_take   = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    cmd.load_track = (operation == OP_TRACK_MUON);
                    cmd.load_muon  = (operation == OP_MUON);
                    if (operation == OP_DECIDE)
                    begin
                        cmd.scan_start = 1'b1;
                        if (zero_bias && !status.any_empty)
                        begin
                            state_next = ST_SCAN;
                        end
                        else
                        begin
                            cmd.clear_counts = 1'b1;
                            out_valid_next   = 1'b1;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (status.pair_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    cmd.clear_counts = 1'b1;
                    out_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

[design/dmpt_datapath.sv]
`default_nettype none

module dmpt_datapath #(
    parameter int MAX_TRACK_MUONS = 16,
    parameter int MAX_MUONS       = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [8:0]         cfg_data,
    input  wire logic signed [3:0]  bunch_crossing,
    input  wire logic [8:0]         pt,
    input  wire logic signed [12:0] eta,
    input  wire logic signed [12:0] phi,
    input  wire logic [3:0]         quality,
    input  wire dmpt_pkg::dmpt_cmd_t cmd,
    output dmpt_pkg::dmpt_status_t  status,
    output logic                    accept
);
    import dmpt_pkg::*;

    localparam int TW = $clog2(MAX_TRACK_MUONS + 1);
    localparam int MW = $clog2(MAX_MUONS + 1);
    localparam int TI = (MAX_TRACK_MUONS > 1) ? $clog2(MAX_TRACK_MUONS) : 1;
    localparam int MI = (MAX_MUONS > 1) ? $clog2(MAX_MUONS) : 1;

    logic [8:0]  track_pt_thr_reg;
    logic [8:0]  muon_pt_thr_reg;
    logic [3:0]  quality_thr_reg;

    dmpt_cand_t  track_mem [MAX_TRACK_MUONS];
    dmpt_cand_t  muon_mem  [MAX_MUONS];

    logic [TW-1:0] track_count_reg;
    logic [MW-1:0] muon_count_reg;
    logic [TI-1:0] ti_reg;
    logic [MI-1:0] mi_reg;

    logic        base_ok;
    logic        track_keep;
    logic        muon_keep;
    logic        ti_last;
    logic        mi_last;
    dmpt_cand_t  new_cand;

    // pair pipeline
    dmpt_cand_t  track_rd_reg;
    dmpt_cand_t  muon_rd_reg;
    logic        rd_valid_reg;
    logic [12:0] eta_abs_reg;
    logic [11:0] phi_mag_reg;
    logic        diff_valid_reg;
    logic [25:0] eta_sq_reg;
    logic [23:0] phi_sq_reg;
    logic        sq_valid_reg;
    logic        hit_reg;

    logic signed [13:0] eta_diff;
    logic signed [13:0] phi_diff;
    logic [13:0]        eta_abs;
    logic [13:0]        phi_abs;
    logic signed [13:0] phi_wrap;
    logic [13:0]        phi_mag;
    logic [26:0]        dr2;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_pt_thr_reg <= TRACK_MUON_PT_THR_RST;
            muon_pt_thr_reg  <= MUON_PT_THR_RST;
            quality_thr_reg  <= QUALITY_THR_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_TRACK_MUON_PT_THR: track_pt_thr_reg <= cfg_data;
                REG_MUON_PT_THR:       muon_pt_thr_reg  <= cfg_data;
                REG_QUALITY_THR:       quality_thr_reg  <= cfg_data[3:0];
                default:               ;
            endcase
        end
    end

    // candidate selection
    assign base_ok    = (bunch_crossing == 4'sd0) && (quality >= quality_thr_reg);
    assign track_keep = cmd.load_track && base_ok && (pt >= track_pt_thr_reg)
                        && (track_count_reg < TW'(MAX_TRACK_MUONS));
    assign muon_keep  = cmd.load_muon && base_ok && (pt >= muon_pt_thr_reg)
                        && (muon_count_reg < MW'(MAX_MUONS));
    assign new_cand   = '{eta: eta, phi: phi};

    // candidate stores
    always_ff @(posedge clk)
    begin
        if (track_keep)
        begin
            track_mem[track_count_reg[TI-1:0]] <= new_cand;
        end
        if (muon_keep)
        begin
            muon_mem[muon_count_reg[MI-1:0]] <= new_cand;
        end
        if (cmd.scan_issue)
        begin
            track_rd_reg <= track_mem[ti_reg];
            muon_rd_reg  <= muon_mem[mi_reg];
        end
    end

    // fill counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_count_reg <= '0;
            muon_count_reg  <= '0;
        end
        else if (cmd.clear_counts)
        begin
            track_count_reg <= '0;
            muon_count_reg  <= '0;
        end
        else
        begin
            if (track_keep)
            begin
                track_count_reg <= track_count_reg + TW'(1);
            end
            if (muon_keep)
            begin
                muon_count_reg <= muon_count_reg + MW'(1);
            end
        end
    end

    // pair walk, standalone index inner
    assign ti_last = ((TW'(ti_reg) + TW'(1)) == track_count_reg);
    assign mi_last = ((MW'(mi_reg) + MW'(1)) == muon_count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ti_reg <= '0;
            mi_reg <= '0;
        end
        else if (cmd.scan_start)
        begin
            ti_reg <= '0;
            mi_reg <= '0;
        end
        else if (cmd.scan_issue)
        begin
            if (mi_last)
            begin
                mi_reg <= '0;
                ti_reg <= ti_reg + TI'(1);
            end
            else
            begin
                mi_reg <= mi_reg + MI'(1);
            end
        end
    end

    // absolute differences, phi folded across pi
    always_comb
    begin
        eta_diff = 14'(track_rd_reg.eta) - 14'(muon_rd_reg.eta);
        phi_diff = 14'(track_rd_reg.phi) - 14'(muon_rd_reg.phi);
        eta_abs  = eta_diff[13] ? 14'(-eta_diff) : 14'(eta_diff);
        phi_abs  = phi_diff[13] ? 14'(-phi_diff) : 14'(phi_diff);
        if (phi_abs >= 14'(PI_FX))
        begin
            phi_wrap = TWO_PI_FX - $signed(phi_abs);
        end
        else
        begin
            phi_wrap = $signed(phi_abs);
        end
        phi_mag = phi_wrap[13] ? 14'(-phi_wrap) : 14'(phi_wrap);
    end

    assign dr2 = 27'(eta_sq_reg) + 27'(phi_sq_reg);

    // pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg   <= 1'b0;
            diff_valid_reg <= 1'b0;
            sq_valid_reg   <= 1'b0;
            hit_reg        <= 1'b0;
        end
        else
        begin
            rd_valid_reg   <= cmd.scan_issue;
            diff_valid_reg <= rd_valid_reg;
            sq_valid_reg   <= diff_valid_reg;
            if (cmd.scan_start)
            begin
                hit_reg <= 1'b0;
            end
            else if (sq_valid_reg && (dr2 > DR2_LIMIT))
            begin
                hit_reg <= 1'b1;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        eta_abs_reg <= eta_abs[12:0];
        phi_mag_reg <= phi_mag[11:0];
        eta_sq_reg  <= 26'(eta_abs_reg) * 26'(eta_abs_reg);
        phi_sq_reg  <= 24'(phi_mag_reg) * 24'(phi_mag_reg);
    end

    assign status.any_empty = (track_count_reg == '0) || (muon_count_reg == '0);
    assign status.pair_last = ti_last && mi_last;
    assign status.pipe_busy = rd_valid_reg || diff_valid_reg || sq_valid_reg;
    assign accept           = hit_reg;

endmodule

`default_nettype wire

[design/dimuon_pair_trigger_delta_r.sv]
`default_nettype none

// channel   direction  handshake              payload
// in        input      in_valid / in_ready    operation zero_bias bunch_crossing pt eta phi
//                                             quality
// out       output     out_valid / out_ready  accept
// cfg       input      cfg_wr_en              cfg_index cfg_data
//
// a candidate is stored if it passes crossing, quality and pt cuts and its store has room
// a decide request walks every pair of stored candidates, one pair read per cycle,
// then difference, square, compare and answer stages
// an empty store or a clear zero-bias bit answers in the cycle after the request is taken
// reset empties both stores; a decide request waits while a previous answer is untaken

module dimuon_pair_trigger_delta_r #(
    parameter int MAX_TRACK_MUONS = 16,
    parameter int MAX_MUONS       = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [8:0]         cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         operation,
    input  wire logic               zero_bias,
    input  wire logic signed [3:0]  bunch_crossing,
    input  wire logic [8:0]         pt,
    input  wire logic signed [12:0] eta,
    input  wire logic signed [12:0] phi,
    input  wire logic [3:0]         quality,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    accept
);
    import dmpt_pkg::*;

    dmpt_cmd_t    cmd;
    dmpt_status_t status;

    // sequencer
    dmpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .zero_bias (zero_bias),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    // stores and pair distance
    dmpt_datapath #(
        .MAX_TRACK_MUONS (MAX_TRACK_MUONS),
        .MAX_MUONS       (MAX_MUONS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .bunch_crossing (bunch_crossing),
        .pt             (pt),
        .eta            (eta),
        .phi            (phi),
        .quality        (quality),
        .cmd            (cmd),
        .status         (status),
        .accept         (accept)
    );

endmodule

`default_nettype wire
